// File: rtl/usp_pkg.sv
// Shared types, character codes and result codes for the URL splitter.
package usp_pkg;

    typedef enum logic [2:0] {
        PH_SCHEME,
        PH_SLASH1,
        PH_SLASH2,
        PH_HOST,
        PH_PORT,
        PH_URI,
        PH_ERROR
    } phase_t;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_HOST = 2'd1;
    localparam logic [1:0] KIND_URI  = 2'd2;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_SCHEME = 2'd1;
    localparam logic [1:0] STATUS_BAD_SEP    = 2'd2;
    localparam logic [1:0] STATUS_BAD_PORT   = 2'd3;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [16:0] PORT_SAT   = 17'd65536;

    localparam int HTTPS_LEN = 5;
    localparam int HTTP_LEN  = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        host_end;
        logic [1:0]  status;
        logic        done;
        logic        tls;
        logic [15:0] port;
    } result_t;

    // One entry per input byte that reports anything; two marks a trailing '/' URI byte.
    typedef struct packed {
        result_t first;
        logic    two;
    } job_t;

    function automatic logic [7:0] https_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h68;
            3'd1:    c = 8'h74;
            3'd2:    c = 8'h74;
            3'd3:    c = 8'h70;
            3'd4:    c = 8'h73;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/usp_front.sv
// Parser front end: tracks the URL phase per byte and queues the results it causes.
module usp_front
    import usp_pkg::*;
#(
    parameter int SCHEME_MAX = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       in_last,
    input  logic       q_ready,
    output logic       push,
    output job_t       job
);

    localparam int CW = $clog2(SCHEME_MAX + 1);

    phase_t      phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next, count_upd;
    logic        match_reg, match_next, match_upd;
    logic [16:0] accum_reg, accum_next, accum_upd;
    logic        seen_reg, seen_next, seen_upd;
    logic        invalid_reg, invalid_next, invalid_upd;
    logic        tls_reg, tls_next, tls_upd;
    logic [15:0] port_reg, port_next, port_upd;
    logic [1:0]  err_reg, err_next, err_upd;

    logic        accept;
    logic        fin;
    logic [7:0]  ch;
    logic        is_slash, is_colon, is_digit;
    logic        is_https, is_http, scheme_full;
    logic [19:0] acc_sum;
    logic [16:0] acc_dig;
    logic [16:0] acc_fin;
    logic        seen_fin, inv_fin, port_good;

    logic        emit;
    logic [1:0]  kind;
    logic        hc;
    logic        two;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign fin      = in_last;
    assign ch       = in_data;

    assign is_slash    = (ch == CH_SLASH);
    assign is_colon    = (ch == CH_COLON);
    assign is_digit    = ch inside {[CH_ZERO:CH_NINE]};
    assign is_https    = match_reg && (count_reg == CW'(HTTPS_LEN));
    assign is_http     = match_reg && (count_reg == CW'(HTTP_LEN));
    assign scheme_full = (count_reg >= CW'(SCHEME_MAX));

    // accum*10 + digit; accum never exceeds the saturation value, so 20 bits hold it
    assign acc_sum = ({3'b000, accum_reg} << 3) + ({3'b000, accum_reg} << 1)
                     + {16'd0, ch[3:0]};
    assign acc_dig = (acc_sum > {3'b000, PORT_SAT}) ? PORT_SAT : acc_sum[16:0];

    assign acc_fin  = (is_slash || !is_digit) ? accum_reg : acc_dig;
    assign seen_fin = is_slash ? seen_reg : (seen_reg || is_digit);
    assign inv_fin  = is_slash ? invalid_reg : (invalid_reg || !is_digit);
    assign port_good = !inv_fin && seen_fin && (acc_fin != 17'd0) && !acc_fin[16];

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_SCHEME:
            begin
                if (is_slash)
                    phase_next = (count_reg != '0) ? PH_ERROR : PH_URI;
                else if (is_colon)
                    phase_next = (is_https || is_http) ? (fin ? PH_ERROR : PH_SLASH1)
                                                       : PH_ERROR;
                else if (fin || scheme_full)
                    phase_next = PH_ERROR;
            end
            PH_SLASH1: phase_next = (is_slash && !fin) ? PH_SLASH2 : PH_ERROR;
            PH_SLASH2: phase_next = (is_slash && !fin) ? PH_HOST : PH_ERROR;
            PH_HOST:
            begin
                if (is_colon)
                    phase_next = PH_PORT;
                else if (is_slash)
                    phase_next = PH_URI;
            end
            PH_PORT:
            begin
                if (is_slash || fin)
                    phase_next = port_good ? PH_URI : PH_ERROR;
            end
            PH_URI:   phase_next = PH_URI;
            default:  phase_next = PH_ERROR;
        endcase
        if (fin)
            phase_next = PH_SCHEME;
    end

    // results and data updates
    always_comb
    begin
        emit        = 1'b0;
        kind        = KIND_NONE;
        hc          = 1'b0;
        two         = 1'b0;
        count_upd   = count_reg;
        match_upd   = match_reg;
        accum_upd   = accum_reg;
        seen_upd    = seen_reg;
        invalid_upd = invalid_reg;
        tls_upd     = tls_reg;
        port_upd    = port_reg;
        err_upd     = err_reg;
        case (phase_reg)
            PH_SCHEME:
            begin
                if (is_slash)
                begin
                    if (count_reg != '0)
                    begin
                        err_upd = STATUS_BAD_SCHEME;
                        emit    = fin;
                    end
                    else
                    begin
                        emit = 1'b1;
                        kind = KIND_URI;
                    end
                end
                else if (is_colon)
                begin
                    if (is_https || is_http)
                    begin
                        tls_upd  = is_https;
                        port_upd = is_https ? PORT_HTTPS : PORT_HTTP;
                        if (fin)
                        begin
                            err_upd = STATUS_BAD_SEP;
                            emit    = 1'b1;
                        end
                    end
                    else
                    begin
                        err_upd = STATUS_BAD_SCHEME;
                        emit    = fin;
                    end
                end
                else if (fin || scheme_full)
                begin
                    err_upd = STATUS_BAD_SCHEME;
                    emit    = fin;
                end
                else
                begin
                    count_upd = count_reg + CW'(1);
                    if (count_reg < CW'(HTTPS_LEN))
                        match_upd = match_reg && (ch == https_char(count_reg[2:0]));
                    else
                        match_upd = 1'b0;
                end
            end
            PH_SLASH1, PH_SLASH2:
            begin
                if (!(is_slash && !fin))
                begin
                    err_upd = STATUS_BAD_SEP;
                    emit    = fin;
                end
            end
            PH_HOST:
            begin
                emit = 1'b1;
                hc   = 1'b1;
                if (is_colon)
                begin
                    if (fin)
                        err_upd = STATUS_BAD_PORT;
                end
                else if (is_slash)
                    kind = KIND_URI;
                else
                begin
                    kind = KIND_HOST;
                    hc   = fin;
                    two  = fin;
                end
            end
            PH_PORT:
            begin
                accum_upd   = acc_fin;
                seen_upd    = seen_fin;
                invalid_upd = inv_fin;
                if (is_slash || fin)
                begin
                    if (port_good)
                    begin
                        port_upd = acc_fin[15:0];
                        emit     = 1'b1;
                        kind     = KIND_URI;
                    end
                    else
                    begin
                        err_upd = STATUS_BAD_PORT;
                        emit    = fin;
                    end
                end
            end
            PH_URI:
            begin
                emit = 1'b1;
                kind = KIND_URI;
            end
            default:
            begin
                emit = fin;
            end
        endcase
    end

    always_comb
    begin
        job.first.kind     = kind;
        job.first.host_end = hc;
        job.first.tls      = tls_upd;
        job.first.port     = port_upd;
        job.two            = two;
        // the first result of a two-result byte never closes the URL
        job.first.done     = fin && !two;
        job.first.status   = (fin && !two) ? err_upd : STATUS_OK;
        if (kind == KIND_NONE)
            job.first.data = 8'd0;
        else if (phase_reg == PH_PORT)
            job.first.data = CH_SLASH;
        else
            job.first.data = ch;
    end

    assign push = accept && emit;

    // drop all state back to its start values after the last byte
    always_comb
    begin
        if (fin)
        begin
            count_next   = '0;
            match_next   = 1'b1;
            accum_next   = '0;
            seen_next    = 1'b0;
            invalid_next = 1'b0;
            tls_next     = 1'b0;
            port_next    = '0;
            err_next     = STATUS_OK;
        end
        else
        begin
            count_next   = count_upd;
            match_next   = match_upd;
            accum_next   = accum_upd;
            seen_next    = seen_upd;
            invalid_next = invalid_upd;
            tls_next     = tls_upd;
            port_next    = port_upd;
            err_next     = err_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SCHEME;
            count_reg   <= '0;
            match_reg   <= 1'b1;
            accum_reg   <= '0;
            seen_reg    <= 1'b0;
            invalid_reg <= 1'b0;
            tls_reg     <= 1'b0;
            port_reg    <= '0;
            err_reg     <= STATUS_OK;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            match_reg   <= match_next;
            accum_reg   <= accum_next;
            seen_reg    <= seen_next;
            invalid_reg <= invalid_next;
            tls_reg     <= tls_next;
            port_reg    <= port_next;
            err_reg     <= err_next;
        end
    end

endmodule

// File: rtl/usp_queue.sv
// Short register queue of result jobs between the parser and the output stage.
module usp_queue
    import usp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic ready,
    input  logic pop,
    output logic valid,
    output job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    job_t          slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign ready   = (fill_reg != NW'(DEPTH));
    assign valid   = (fill_reg != '0);
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            fill_next = fill_reg + NW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_job;
    end

endmodule

// File: rtl/usp_back.sv
// Output stage: expands queued jobs into result transfers through an output register.
module usp_back
    import usp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  job_t        q_head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic    valid_reg, valid_next;
    logic    sub_reg, sub_next;
    result_t res_reg, res_next;
    logic    last_reg, last_next;
    logic    load;
    result_t second;

    assign load = q_valid && (!valid_reg || m_tready);
    assign pop  = load && (sub_reg || !q_head.two);

    always_comb
    begin
        second          = q_head.first;
        second.kind     = KIND_URI;
        second.data     = CH_SLASH;
        second.host_end = 1'b0;
        second.status   = STATUS_OK;
        second.done     = 1'b1;
    end

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        res_next   = res_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (sub_reg)
            begin
                res_next  = second;
                last_next = 1'b1;
                sub_next  = 1'b0;
            end
            else
            begin
                res_next  = q_head.first;
                last_next = !q_head.two;
                sub_next  = q_head.two;
            end
        end
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = last_reg;
    assign m_tdata  = {3'b000, res_reg.port, res_reg.tls, res_reg.done,
                       res_reg.status, res_reg.host_end, res_reg.data};

endmodule

// File: rtl/url_scheme_host_port_splitter_unit.sv
// Top level of the http/https URL scheme, host and port splitter.
//
//  channel  dir  tdata                               tuser      tlast
//  s_*      in   [7:0] url_byte                      -          final_byte
//  m_*      out  [7:0] out_byte, [8] host_complete,  [1:0]      run_last
//                [10:9] status, [11] url_done,       byte_kind
//                [12] tls_on, [28:13] port_value
//
//  One input byte is taken every cycle while the job queue has room; the parser updates
//  its phase in the cycle of the transfer and queues at most one job. A plain host byte
//  that ends a URL gives two results, which leave the output register one after the other.
//  Each result passes through the job queue and then the output register.
//  s_tready drops only when the QUEUE_DEPTH job queue is full, chiefly under output backpressure.
//  Reset is asynchronous and leaves the parser in the scheme phase with the queue empty.
module url_scheme_host_port_splitter_unit
    import usp_pkg::*;
#(
    parameter int SCHEME_MAX  = 6,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] url_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [8] host_complete, [10:9] status,
                                   // [11] url_done, [12] tls_on, [28:13] port_value
    output logic [1:0]  m_tuser,   // [1:0] byte_kind
    output logic        m_tlast
);

    logic q_ready, q_valid, push, pop;
    job_t push_job, q_head;

    usp_front #(
        .SCHEME_MAX(SCHEME_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .q_ready  (q_ready),
        .push     (push),
        .job      (push_job)
    );

    usp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .ready    (q_ready),
        .pop      (pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    usp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/usp_checker.sv
// Port-level assertions for the URL splitter, bound to the top level.
module usp_checker
    import usp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // hold a stalled result transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[11] |-> m_tlast)
        else $error("url_done without run_last");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[10:9] != STATUS_OK) |-> m_tdata[11])
        else $error("error status outside the closing result");

    a_kind_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_NONE) |-> (m_tdata[7:0] == 8'd0))
        else $error("byte present with no byte kind");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> (m_tuser != KIND_HOST) || m_tlast || !m_tdata[11])
        else $error("host end flag on a closing host byte");

endmodule

bind url_scheme_host_port_splitter_unit usp_checker u_usp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
